// ===== hw/rtl/telnet_receive_deframer_assert.svh =====
// ---------------------------------------------------------------------------
// Telnet receive deframer assertion macros
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef TELNET_RECEIVE_DEFRAMER_ASSERT_SVH
`define TELNET_RECEIVE_DEFRAMER_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define TRD_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define TRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/trd_pkg.sv =====
// ---------------------------------------------------------------------------
// Telnet receive deframer package
// Protocol byte codes, parser states and result types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package trd_pkg;

    localparam logic [7:0] IAC  = 8'd255;
    localparam logic [7:0] SE   = 8'd240;
    localparam logic [7:0] SB   = 8'd250;
    localparam logic [7:0] WILL = 8'd251;
    localparam logic [7:0] WONT = 8'd252;
    localparam logic [7:0] DO   = 8'd253;
    localparam logic [7:0] DONT = 8'd254;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    typedef enum logic [2:0] {
        K_DATA = 3'd0,
        K_CMD  = 3'd1,
        K_NEG  = 3'd2,
        K_SUB  = 3'd3,
        K_END  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_IAC   = 3'd1,
        ST_VERB  = 3'd2,
        ST_SBOPT = 3'd3,
        ST_INSB  = 3'd4,
        ST_SBIAC = 3'd5
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  code;
        logic [7:0]  option;
        logic [7:0]  value;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]  count;
        t_result     res0;
        t_result     res1;
    } t_parse;

endpackage

// ===== hw/rtl/trd_parser.sv =====
// ---------------------------------------------------------------------------
// Telnet receive deframer parser
// Byte-wise command state machine that turns each request into zero, one or
// two results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trd_parser
    import trd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    output t_parse      o_parse
);

    t_state      r_state, n_state;
    logic [7:0]  r_verb, n_verb;
    logic [7:0]  r_sub_opt, n_sub_opt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_verb    <= '0;
            r_sub_opt <= '0;
        end else if (i_accept) begin
            r_state   <= n_state;
            r_verb    <= n_verb;
            r_sub_opt <= n_sub_opt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_verb    = r_verb;
        n_sub_opt = r_sub_opt;
        o_parse   = '0;
        unique case (r_state)
            ST_IAC: begin
                if (i_byte == WILL || i_byte == WONT || i_byte == DO || i_byte == DONT) begin
                    n_verb  = i_byte;
                    n_state = ST_VERB;
                end else if (i_byte == SB) begin
                    n_state = ST_SBOPT;
                end else begin
                    n_state            = ST_IDLE;
                    o_parse.count      = 2'd1;
                    o_parse.res0.kind  = K_CMD;
                    o_parse.res0.code  = i_byte;
                    o_parse.res0.last  = 1'b1;
                end
            end
            ST_VERB: begin
                n_state              = ST_IDLE;
                o_parse.count        = 2'd1;
                o_parse.res0.kind    = K_NEG;
                o_parse.res0.code    = r_verb;
                o_parse.res0.option  = i_byte;
                o_parse.res0.last    = 1'b1;
            end
            ST_SBOPT: begin
                n_sub_opt = i_byte;
                n_state   = ST_INSB;
            end
            ST_INSB: begin
                if (i_byte == IAC) begin
                    n_state = ST_SBIAC;
                end else begin
                    o_parse.count        = 2'd1;
                    o_parse.res0.kind    = K_SUB;
                    o_parse.res0.option  = r_sub_opt;
                    o_parse.res0.value   = i_byte;
                    o_parse.res0.last    = 1'b1;
                end
            end
            ST_SBIAC: begin
                if (i_byte == SE) begin
                    n_state              = ST_IDLE;
                    o_parse.count        = 2'd1;
                    o_parse.res0.kind    = K_END;
                    o_parse.res0.option  = r_sub_opt;
                    o_parse.res0.last    = 1'b1;
                end else begin
                    n_state              = ST_INSB;
                    o_parse.count        = 2'd2;
                    o_parse.res0.kind    = K_SUB;
                    o_parse.res0.option  = r_sub_opt;
                    o_parse.res0.value   = IAC;
                    o_parse.res1.kind    = K_SUB;
                    o_parse.res1.option  = r_sub_opt;
                    o_parse.res1.value   = i_byte;
                    o_parse.res1.last    = 1'b1;
                end
            end
            default: begin
                if (i_byte == IAC) begin
                    n_state = ST_IAC;
                end else begin
                    n_state            = ST_IDLE;
                    o_parse.count      = 2'd1;
                    o_parse.res0.kind  = K_DATA;
                    o_parse.res0.value = i_byte;
                    o_parse.res0.last  = 1'b1;
                end
            end
        endcase
    end

endmodule

// ===== hw/rtl/telnet_receive_deframer.sv =====
// Output: each result is written into the result queue when its byte is accepted.
// Throughput: one byte per cycle while o_s_axis_tready is high; a byte that yields
// two results is read out as two output transfers, and the four-entry result queue
// holds off new bytes while fewer than two entries are free.
// Reset: synchronous active-low reset returns the parser to idle and empties
// the result queue.
// ---------------------------------------------------------------------------
// Telnet receive deframer
// Sorts a received telnet byte stream into data, command, negotiation and
// subnegotiation results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module telnet_receive_deframer
    import trd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] code, [15:8] option, [23:16] value
    output logic [2:0]  o_m_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tlast
);

    logic             w_accept;
    logic             w_pop;
    t_parse           w_parse;
    t_result          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0]   r_count, n_count;
    logic [QCW-1:0]   w_push_cnt;
    t_result          w_head;

    assign o_s_axis_tready = (r_count <= QCW'(QDEPTH - 2));
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_count != '0);
    assign w_pop           = o_m_axis_tvalid && i_m_axis_tready;

    trd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_axis_tdata),
        .o_parse  (w_parse)
    );

    assign w_push_cnt = w_accept ? QCW'(w_parse.count) : '0;

    always_comb begin
        n_wr_ptr = r_wr_ptr + QAW'(w_push_cnt);
        n_rd_ptr = r_rd_ptr + QAW'(w_pop);
        n_count  = r_count + w_push_cnt - QCW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_cnt != '0) begin
            r_mem[r_wr_ptr] <= w_parse.res0;
        end
        if (w_push_cnt == QCW'(2)) begin
            r_mem[QAW'(r_wr_ptr + 1'b1)] <= w_parse.res1;
        end
    end

    assign w_head          = r_mem[r_rd_ptr];
    assign o_m_axis_tdata  = {w_head.value, w_head.option, w_head.code};
    assign o_m_axis_tuser  = w_head.kind;
    assign o_m_axis_tlast  = w_head.last;

endmodule

// ===== hw/rtl/trd_checker.sv =====
// ---------------------------------------------------------------------------
// Telnet receive deframer checker
// Port-level assertions on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "telnet_receive_deframer_assert.svh"

module trd_checker
    import trd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_s_axis_tready,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [23:0] o_m_axis_tdata,
    input  logic [2:0]  o_m_axis_tuser,
    input  logic        o_m_axis_tlast
);

    logic [27:0] w_out_bus;
    logic        w_out_stall;
    logic        w_is_data;
    logic        w_is_end;
    logic        w_is_sub;

    assign w_out_bus   = {o_m_axis_tlast, o_m_axis_tuser, o_m_axis_tdata};
    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_is_data   = o_m_axis_tvalid && (o_m_axis_tuser == K_DATA);
    assign w_is_end    = o_m_axis_tvalid && (o_m_axis_tuser == K_END);
    assign w_is_sub    = o_m_axis_tvalid && (o_m_axis_tuser == K_SUB);

    `TRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_m_axis_tvalid && $stable(w_out_bus))
    `TRD_ASSERT_ALWAYS(a_data_clean, i_clk, i_rst_n, !w_is_data || (o_m_axis_tdata[15:0] == 16'd0 && o_m_axis_tlast))
    `TRD_ASSERT_ALWAYS(a_end_clean, i_clk, i_rst_n, !w_is_end || (o_m_axis_tdata[23:16] == 8'd0 && o_m_axis_tdata[7:0] == 8'd0 && o_m_axis_tlast))
    `TRD_ASSERT_ALWAYS(a_sub_code, i_clk, i_rst_n, !w_is_sub || (o_m_axis_tdata[7:0] == 8'd0))
    `TRD_ASSERT_ALWAYS(a_full_valid, i_clk, i_rst_n, o_s_axis_tready || o_m_axis_tvalid)

endmodule

bind telnet_receive_deframer trd_checker u_trd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
